### rtl/ipp_pkg.sv
`timescale 1ns / 1ps
package ipp_pkg;

	localparam int CHAR_W = 16;
	localparam int ADDR_W = 32;
	localparam int PORT_W = 16;

	localparam logic [1:0] PH_ADDR = 2'd0;
	localparam logic [1:0] PH_PORT = 2'd1;
	localparam logic [1:0] PH_SKIP = 2'd2;

	localparam logic [1:0] RDX_DEC = 2'd0;
	localparam logic [1:0] RDX_OCT = 2'd1;
	localparam logic [1:0] RDX_HEX = 2'd2;

	localparam logic [1:0] NUM_TAKEN = 2'd0;
	localparam logic [1:0] NUM_END   = 2'd1;
	localparam logic [1:0] NUM_BAD   = 2'd2;

	localparam logic [CHAR_W-1:0] CH_NUL    = 16'h0000;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 16'h0030;
	localparam logic [CHAR_W-1:0] CH_NINE   = 16'h0039;
	localparam logic [CHAR_W-1:0] CH_LC_A   = 16'h0061;
	localparam logic [CHAR_W-1:0] CH_LC_F   = 16'h0066;
	localparam logic [CHAR_W-1:0] CH_UC_A   = 16'h0041;
	localparam logic [CHAR_W-1:0] CH_UC_F   = 16'h0046;
	localparam logic [CHAR_W-1:0] CH_LC_X   = 16'h0078;
	localparam logic [CHAR_W-1:0] CH_UC_X   = 16'h0058;
	localparam logic [CHAR_W-1:0] CH_DOT    = 16'h002E;
	localparam logic [CHAR_W-1:0] CH_COLON  = 16'h003A;

	localparam logic [1:0] LAST_PART = 2'd3;

	typedef struct packed {
		logic [1:0]        phase;
		logic [1:0]        radix;
		logic [1:0]        dcount;
		logic [ADDR_W-1:0] acc;
		logic [1:0]        pcount;
		logic [23:0]       leading;
		logic              too_big;
		logic              err;
		logic              done;
		logic [ADDR_W-1:0] hold;
	} ipp_state_t;

	localparam ipp_state_t IPP_STATE_RESET = '{
		phase:   PH_ADDR,
		radix:   RDX_DEC,
		dcount:  2'd0,
		acc:     '0,
		pcount:  2'd0,
		leading: '0,
		too_big: 1'b0,
		err:     1'b0,
		done:    1'b0,
		hold:    '0
	};

	typedef struct packed {
		logic              status;
		logic              address_committed;
		logic [ADDR_W-1:0] address;
		logic [PORT_W-1:0] port_net_order;
	} ipp_result_t;

endpackage

### rtl/ipp_if.sv
`timescale 1ns / 1ps
interface ipp_char_if
	import ipp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] text_char;

	modport source (output valid, output text_char, input ready);
	modport sink (input valid, input text_char, output ready);
endinterface

interface ipp_result_if
	import ipp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              status;
	logic              address_committed;
	logic [ADDR_W-1:0] address;
	logic [PORT_W-1:0] port_net_order;

	modport source (output valid, output status, output address_committed,
		output address, output port_net_order, input ready);
	modport sink (input valid, input status, input address_committed,
		input address, input port_net_order, output ready);
endinterface

### rtl/ipp_step.sv
`timescale 1ns / 1ps
module ipp_step
	import ipp_pkg::*;
(
	input  ipp_state_t        cur,
	input  logic [CHAR_W-1:0] c,
	input  logic              strict,
	output ipp_state_t        nxt,
	output ipp_result_t       res
);

	logic              strict_eff;
	logic              is_x;
	logic              is_dig;
	logic              is_hex_ltr;
	logic              d_ok;
	logic [3:0]        d;
	logic              ge_base;
	logic [35:0]       scaled;
	logic [35:0]       acc_sum;
	logic [1:0]        num_res;
	logic [1:0]        num_radix;
	logic [1:0]        num_dcount;
	logic [ADDR_W-1:0] num_acc;
	logic              over_lim;
	logic [ADDR_W-1:0] hold_new;
	logic [PORT_W-1:0] port_v;

	assign strict_eff = (cur.phase == PH_ADDR) && strict;
	assign is_x       = (c == CH_LC_X) || (c == CH_UC_X);
	assign is_dig     = (c >= CH_ZERO) && (c <= CH_NINE);
	assign is_hex_ltr = (cur.radix == RDX_HEX) &&
		(((c >= CH_LC_A) && (c <= CH_LC_F)) || ((c >= CH_UC_A) && (c <= CH_UC_F)));
	assign d_ok       = is_dig || is_hex_ltr;
	// letters a-f and A-F share the low nibble 1..6
	assign d          = is_dig ? c[3:0] : (c[3:0] + 4'd9);
	assign ge_base    = (cur.radix == RDX_OCT) && (d >= 4'd8);

	always_comb begin
		unique case (cur.radix)
			RDX_HEX: scaled = {cur.acc, 4'b0};
			RDX_OCT: scaled = {1'b0, cur.acc, 3'b0};
			default: scaled = {1'b0, cur.acc, 3'b0} + {3'b0, cur.acc, 1'b0};
		endcase
	end

	assign acc_sum = scaled + {32'b0, d};

	// one character into the current number
	always_comb begin
		num_res    = NUM_TAKEN;
		num_radix  = cur.radix;
		num_dcount = cur.dcount;
		num_acc    = cur.acc;
		priority if (cur.dcount == 2'd0 && cur.radix == RDX_DEC && c == CH_ZERO
			&& !strict_eff) begin
			num_radix  = RDX_OCT;
			num_dcount = 2'd1;
			num_acc    = '0;
		end else if (cur.radix == RDX_OCT && cur.dcount == 2'd1 && is_x) begin
			num_radix  = RDX_HEX;
			num_dcount = 2'd0;
			num_acc    = '0;
		end else if (strict_eff && cur.radix == RDX_DEC && cur.dcount == 2'd1
			&& cur.acc == '0 && (is_x || d_ok)) begin
			num_res = NUM_BAD;
		end else if (!d_ok) begin
			num_res = NUM_END;
		end else if (ge_base) begin
			num_res = (cur.dcount == 2'd1) ? NUM_BAD : NUM_END;
		end else begin
			num_acc = acc_sum[ADDR_W-1:0];
			if (cur.dcount != 2'd2) begin
				num_dcount = cur.dcount + 2'd1;
			end
			if (acc_sum[35:32] != 4'd0) begin
				num_res = NUM_BAD;
			end
		end
	end

	// last part fills the bytes left over by the leading parts
	always_comb begin
		unique case (cur.pcount)
			2'd0: begin
				over_lim = 1'b0;
				hold_new = cur.acc;
			end
			2'd1: begin
				over_lim = (cur.acc[31:24] != 8'd0);
				hold_new = {cur.leading[7:0], 24'b0} | cur.acc;
			end
			2'd2: begin
				over_lim = (cur.acc[31:16] != 16'd0);
				hold_new = {cur.leading[15:0], 16'b0} | cur.acc;
			end
			default: begin
				over_lim = (cur.acc[31:8] != 24'd0);
				hold_new = {cur.leading, 8'b0} | cur.acc;
			end
		endcase
	end

	always_comb begin
		nxt    = cur;
		port_v = '0;
		unique case (cur.phase)
			PH_ADDR: begin
				nxt.radix  = num_radix;
				nxt.dcount = num_dcount;
				nxt.acc    = num_acc;
				if (num_res == NUM_BAD) begin
					nxt.err   = 1'b1;
					nxt.phase = PH_SKIP;
				end else if (num_res == NUM_END) begin
					if (cur.dcount == 2'd0) begin
						nxt.err   = 1'b1;
						nxt.phase = PH_SKIP;
					end else if (c == CH_DOT) begin
						if (cur.pcount == LAST_PART) begin
							nxt.err   = 1'b1;
							nxt.phase = PH_SKIP;
						end else begin
							if (cur.acc[31:8] != 24'd0) begin
								nxt.too_big = 1'b1;
							end
							nxt.leading = {cur.leading[15:0], cur.acc[7:0]};
							nxt.pcount  = cur.pcount + 2'd1;
							nxt.radix   = RDX_DEC;
							nxt.dcount  = 2'd0;
							nxt.acc     = '0;
						end
					end else if (cur.too_big || over_lim
						|| (strict && cur.pcount != LAST_PART)) begin
						nxt.err   = 1'b1;
						nxt.phase = PH_SKIP;
					end else begin
						nxt.hold = hold_new;
						nxt.done = 1'b1;
						if (c == CH_COLON) begin
							nxt.phase  = PH_PORT;
							nxt.radix  = RDX_DEC;
							nxt.dcount = 2'd0;
							nxt.acc    = '0;
						end else if (c != CH_NUL) begin
							nxt.err   = 1'b1;
							nxt.phase = PH_SKIP;
						end
					end
				end
			end
			PH_PORT: begin
				nxt.radix  = num_radix;
				nxt.dcount = num_dcount;
				nxt.acc    = num_acc;
				if (num_res == NUM_BAD) begin
					nxt.err   = 1'b1;
					nxt.phase = PH_SKIP;
				end else if (num_res == NUM_END) begin
					if (c != CH_NUL || cur.dcount == 2'd0
						|| (cur.radix == RDX_OCT && cur.dcount == 2'd1)
						|| cur.acc[31:16] != 16'd0) begin
						nxt.err   = 1'b1;
						nxt.phase = PH_SKIP;
					end else begin
						port_v = {cur.acc[7:0], cur.acc[15:8]};
					end
				end
			end
			default: begin
				// drop characters until the terminator
			end
		endcase

		res.status            = nxt.err;
		res.address_committed = nxt.done;
		res.address           = nxt.done ? nxt.hold : '0;
		res.port_net_order    = nxt.err ? '0 : port_v;

		if (c == CH_NUL) begin
			nxt = IPP_STATE_RESET;
		end
	end

endmodule

### rtl/ipp_out_reg.sv
`timescale 1ns / 1ps
module ipp_out_reg
	import ipp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  ipp_result_t         res,
	output logic                can_load,
	ipp_result_if.source        out_ch
);

	logic        valid_q;
	ipp_result_t res_q;

	assign can_load = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_ch.valid             = valid_q;
	assign out_ch.status            = res_q.status;
	assign out_ch.address_committed = res_q.address_committed;
	assign out_ch.address           = res_q.address;
	assign out_ch.port_net_order    = res_q.port_net_order;

endmodule

### rtl/ipv4_port_text_parser_top.sv
`timescale 1ns / 1ps
// A terminating word's result goes through the input and result registers to out_ch.
// Throughput: one character word per cycle; the input register and the result
// register decouple the two sides, so only a held result stalls a terminator.
// Reset (arst_n low, asynchronous): parser back to the first address part,
// strict_mode cleared, input and result registers empty.
module ipv4_port_text_parser_top
	import ipp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic          cfg_wr_data,
	ipp_char_if.sink      in_ch,
	ipp_result_if.source  out_ch
);

	logic              strict_q;
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	ipp_state_t        state_q;
	ipp_state_t        state_nxt;
	ipp_result_t       res;
	logic              can_load;
	logic              adv;
	logic              term_s1;

	assign term_s1     = (char_s1 == CH_NUL);
	// advance unless a terminator waits on a held result
	assign adv         = valid_s1 && (!term_s1 || can_load);
	assign in_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q <= 1'b0;
		end else if (cfg_wr_en) begin
			strict_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			char_s1 <= in_ch.text_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IPP_STATE_RESET;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	ipp_step u_step (
		.cur    (state_q),
		.c      (char_s1),
		.strict (strict_q),
		.nxt    (state_nxt),
		.res    (res)
	);

	ipp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv && term_s1),
		.res      (res),
		.can_load (can_load),
		.out_ch   (out_ch)
	);

endmodule

### dv/ipp_result_checker.sv
`timescale 1ns / 1ps
module ipp_result_checker
	import ipp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [CHAR_W-1:0] in_char,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic              out_status,
	input  logic              out_committed,
	input  logic [ADDR_W-1:0] out_address,
	input  logic [PORT_W-1:0] out_port,
	output int                mismatches,
	output int                pending,
	output int                checked
);

	logic              strict_q;
	logic [1:0]        ph;
	logic [1:0]        rdx;
	logic [1:0]        ndig;
	logic [63:0]       acc;
	int unsigned       parts;
	logic [23:0]       lead;
	logic              big;
	logic              err;
	logic              done;
	logic [ADDR_W-1:0] hold;

	ipp_result_t parsed_q[$];
	ipp_result_t new_result;
	ipp_result_t want;

	function automatic void clear_number();
		rdx = RDX_DEC;
		ndig = 2'd0;
		acc = '0;
	endfunction

	function automatic void reset_parser();
		ph = PH_ADDR;
		clear_number();
		parts = 0;
		lead = '0;
		big = 1'b0;
		err = 1'b0;
		done = 1'b0;
		hold = '0;
	endfunction

	function automatic void mark_error();
		err = 1'b1;
		ph = PH_SKIP;
	endfunction

	function automatic logic [1:0] take_digit(input logic [CHAR_W-1:0] c, input logic strict_eff);
		int   base;
		int   d;
		logic is_x;
		base = (rdx == RDX_HEX) ? 16 : (rdx == RDX_OCT) ? 8 : 10;
		d = -1;
		is_x = (c == CH_LC_X) || (c == CH_UC_X);
		// lone leading zero switches to octal, "0x" then to hex
		if (ndig == 2'd0 && rdx == RDX_DEC && c == CH_ZERO && !strict_eff) begin
			rdx = RDX_OCT;
			ndig = 2'd1;
			acc = '0;
			return NUM_TAKEN;
		end
		if (rdx == RDX_OCT && ndig == 2'd1 && is_x) begin
			rdx = RDX_HEX;
			ndig = 2'd0;
			acc = '0;
			return NUM_TAKEN;
		end
		if (c >= CH_ZERO && c <= CH_NINE)
			d = int'(c) - int'(CH_ZERO);
		else if (rdx == RDX_HEX && c >= CH_LC_A && c <= CH_LC_F)
			d = int'(c) - int'(CH_LC_A) + 10;
		else if (rdx == RDX_HEX && c >= CH_UC_A && c <= CH_UC_F)
			d = int'(c) - int'(CH_UC_A) + 10;
		if (strict_eff && rdx == RDX_DEC && ndig == 2'd1 && acc == 0 && (is_x || d >= 0))
			return NUM_BAD;
		if (d < 0)
			return NUM_END;
		if (d >= base)
			return (ndig == 2'd1) ? NUM_BAD : NUM_END;
		acc = acc * 64'(base) + 64'(d);
		if (ndig < 2'd2)
			ndig = ndig + 2'd1;
		if (acc > 64'hFFFF_FFFF)
			return NUM_BAD;
		return NUM_TAKEN;
	endfunction

	function automatic void close_part(input logic [CHAR_W-1:0] c, input logic strict_eff);
		int unsigned n;
		logic [63:0] lim;
		logic [63:0] wide;
		if (ndig == 2'd0) begin
			mark_error();
			return;
		end
		if (c == CH_DOT) begin
			if (parts >= 3) begin
				mark_error();
				return;
			end
			if (acc > 64'hFF)
				big = 1'b1;
			lead = {lead[15:0], acc[7:0]};
			parts = parts + 1;
			clear_number();
			return;
		end
		// last part fills whatever bytes the leading parts left
		n = parts + 1;
		lim = (n >= 4) ? 64'hFF : (n == 3) ? 64'hFFFF : (n == 2) ? 64'hFF_FFFF : 64'hFFFF_FFFF;
		if (big || acc > lim || (strict_eff && n != 4)) begin
			mark_error();
			return;
		end
		wide = (64'(lead) << (32 - 8 * (parts % 4))) | acc;
		hold = wide[31:0];
		done = 1'b1;
		if (c == CH_COLON) begin
			ph = PH_PORT;
			clear_number();
		end else if (c != CH_NUL) begin
			mark_error();
		end
	endfunction

	function automatic bit consume_char(input logic [CHAR_W-1:0] c, output ipp_result_t r);
		logic [1:0]        verdict;
		logic [PORT_W-1:0] pv;
		logic [PORT_W-1:0] port;
		port = '0;
		r = '0;
		if (ph == PH_ADDR) begin
			verdict = take_digit(c, strict_q);
			if (verdict == NUM_BAD)
				mark_error();
			else if (verdict == NUM_END)
				close_part(c, strict_q);
		end else if (ph == PH_PORT) begin
			verdict = take_digit(c, 1'b0);
			if (verdict == NUM_BAD) begin
				mark_error();
			end else if (verdict == NUM_END) begin
				if (c != CH_NUL || ndig == 2'd0 || (rdx == RDX_OCT && ndig == 2'd1)
						|| acc > 64'hFFFF) begin
					mark_error();
				end else begin
					pv = acc[15:0];
					port = {pv[7:0], pv[15:8]};
				end
			end
		end
		if (c != CH_NUL)
			return 1'b0;
		r.status = err;
		r.address_committed = done;
		r.address = done ? hold : '0;
		r.port_net_order = err ? '0 : port;
		reset_parser();
		return 1'b1;
	endfunction

	function automatic void check_field(input string what, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$display("%t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q = 1'b0;
			reset_parser();
			parsed_q.delete();
			mismatches = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (in_valid && in_ready && consume_char(in_char, new_result))
				parsed_q.push_back(new_result);
			if (cfg_wr_en)
				strict_q = cfg_wr_data;
			if (out_valid && out_ready) begin
				if (parsed_q.size() == 0) begin
					$display("%t: unexpected result, expected none, actual %b %b %h %h", $time,
						out_status, out_committed, out_address, out_port);
					mismatches++;
				end else begin
					want = parsed_q.pop_front();
					check_field("status", 32'(want.status), 32'(out_status));
					check_field("address_committed", 32'(want.address_committed),
						32'(out_committed));
					check_field("address", want.address, out_address);
					check_field("port_net_order", 32'(want.port_net_order), 32'(out_port));
					checked++;
				end
			end
			pending = parsed_q.size();
		end
	end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import ipp_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;

	int mismatches;
	int pending;
	int checked;
	int cycles = 0;
	int chars_sent = 0;
	int strings_sent = 0;
	int sink_hold = 0;
	bit idle_on = 1'b0;
	bit strict_now = 1'b0;

	ipp_char_if   char_ch();
	ipp_result_if res_ch();

	ipv4_port_text_parser_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_ch      (char_ch),
		.out_ch     (res_ch)
	);

	ipp_result_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (char_ch.valid),
		.in_ready     (char_ch.ready),
		.in_char      (char_ch.text_char),
		.out_valid    (res_ch.valid),
		.out_ready    (res_ch.ready),
		.out_status   (res_ch.status),
		.out_committed(res_ch.address_committed),
		.out_address  (res_ch.address),
		.out_port     (res_ch.port_net_order),
		.mismatches   (mismatches),
		.pending      (pending),
		.checked      (checked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		char_ch.valid = 1'b0;
		char_ch.text_char = '0;
		res_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still expected", cycles, pending);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side: random stall bursts
	always @(posedge clk) begin
		if (sink_hold != 0) begin
			res_ch.ready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			res_ch.ready <= 1'b0;
			sink_hold <= $urandom_range(0, 12);
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	task automatic send_char(input logic [CHAR_W-1:0] c);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			char_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		char_ch.valid <= 1'b1;
		char_ch.text_char <= c;
		do @(posedge clk); while (!char_ch.ready);
		chars_sent++;
	endtask

	task automatic send_string(input logic [CHAR_W-1:0] q[$]);
		foreach (q[i])
			send_char(q[i]);
		strings_sent++;
	endtask

	task automatic run_text(input string s);
		logic [CHAR_W-1:0] q[$];
		foreach (s[i])
			q.push_back(16'(s[i]));
		q.push_back(CH_NUL);
		send_string(q);
	endtask

	// drop valid and let every pending result drain before touching the mode
	task automatic drain();
		char_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_mode(input bit m);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		strict_now = m;
	endtask

	function automatic logic [63:0] pick_value(input logic [63:0] lim);
		case ($urandom_range(0, 15))
			0: return 64'd0;
			1: return lim;
			2: return lim + 64'd1;
			3: return {31'd0, 1'b1, 32'($urandom)};
			default: begin
				if (lim > 64'hFFFF_FFFE)
					return 64'($urandom);
				return 64'($urandom_range(0, 32'(lim)));
			end
		endcase
	endfunction

	function automatic void append_number(ref logic [CHAR_W-1:0] q[$], input logic [63:0] v,
			input logic [1:0] radix);
		int                base;
		bit                upper;
		logic [63:0]       d;
		logic [CHAR_W-1:0] digs[$];
		base = (radix == RDX_HEX) ? 16 : (radix == RDX_OCT) ? 8 : 10;
		upper = $urandom_range(0, 1);
		if (radix == RDX_HEX) begin
			q.push_back(CH_ZERO);
			q.push_back(upper ? CH_UC_X : CH_LC_X);
		end else if (radix == RDX_OCT && v != 0) begin
			q.push_back(CH_ZERO);
		end
		do begin
			d = v % 64'(base);
			digs.push_front(d < 10 ? CH_ZERO + 16'(d) : (upper ? CH_UC_A : CH_LC_A) + 16'(d - 10));
			v = v / 64'(base);
		end while (v != 0);
		foreach (digs[i])
			q.push_back(digs[i]);
	endfunction

	function automatic void build_random(ref logic [CHAR_W-1:0] q[$], input bit strict_m);
		int          nparts;
		int          pos;
		logic [63:0] lim;
		logic [1:0]  radix;
		string       odd;
		odd = "x89g.:F ";
		// pure noise now and then, full 16-bit code units
		if ($urandom_range(0, 19) == 0) begin
			repeat ($urandom_range(1, 6)) q.push_back(16'($urandom_range(1, 65535)));
			q.push_back(CH_NUL);
			return;
		end
		if (strict_m)
			nparts = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : 4;
		else
			nparts = ($urandom_range(0, 19) == 0) ? 5 : $urandom_range(1, 4);
		for (int i = 0; i < nparts; i++) begin
			if (i < nparts - 1 || nparts >= 4)
				lim = 64'hFF;
			else if (nparts == 3)
				lim = 64'hFFFF;
			else if (nparts == 2)
				lim = 64'hFF_FFFF;
			else
				lim = 64'hFFFF_FFFF;
			if (strict_m && $urandom_range(0, 9) != 0)
				radix = RDX_DEC;
			else
				radix = 2'($urandom_range(0, 2));
			append_number(q, pick_value(lim), radix);
			if (i < nparts - 1)
				q.push_back(CH_DOT);
		end
		if ($urandom_range(0, 2) != 0) begin
			q.push_back(CH_COLON);
			append_number(q, pick_value(64'hFFFF), 2'($urandom_range(0, 2)));
		end
		// break a well-formed string once in a while
		if ($urandom_range(0, 7) == 0) begin
			pos = $urandom_range(0, q.size() - 1);
			case ($urandom_range(0, 2))
				0: q.insert(pos, 16'($urandom));
				1: q.delete(pos);
				default: q[pos] = 16'(odd[$urandom_range(0, 7)]);
			endcase
		end
		q.push_back(CH_NUL);
	endfunction

	task automatic run_random(input int n_chars, input int calm_chars);
		int                stop;
		logic [CHAR_W-1:0] q[$];
		stop = chars_sent + n_chars;
		while (chars_sent < stop) begin
			q.delete();
			idle_on = (stop - chars_sent > calm_chars) && ($urandom_range(0, 4) != 0);
			build_random(q, strict_now);
			send_string(q);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_mode(1'b0);
		idle_on = 1'b1;
		run_text("255.255.255.255:65535");
		run_text("0.0.0.0");
		run_text("4294967295");
		run_text("4294967296");
		run_text("0xFFFFFFFF");
		run_text("0Xabcdef12");
		run_text("037777777777");
		run_text("1.2.3");
		run_text("1.16777215");
		run_text("1..2");
		run_text("");
		run_text("1.2.3.4.5");
		run_text("08");
		run_text("017.018");
		run_text("1.2.3.4x");
		run_text("1.2.3.4:0");
		run_text("1.2.3.4:");
		run_text("10.0.0.1:0x50");
		run_text("1.2.3.4:65536");
		run_text("1.2.3.4:22z");
		run_text("256.1.1.1");
		run_text("0x");
		send_string('{16'h8031, 16'hFFFF, CH_NUL});

		set_mode(1'b1);
		run_text("1.2.3.4");
		run_text("01.2.3.4");
		run_text("1.2.3");
		run_text("0x1.2.3.4");
		run_text("0.0.0.0:0x1F90");
		run_text("255.255.255.255");

		run_random(600, 0);
		set_mode(1'b0);
		run_random(1400, 300);

		idle_on = 1'b0;
		drain();
		repeat (8) @(posedge clk);
		$display("Covered %0d strings (%0d characters) in lax and strict address modes",
			strings_sent, chars_sent);
		$display("%0d results compared, %0d mismatches", checked, mismatches);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### filelist.f
rtl/ipp_pkg.sv
rtl/ipp_if.sv
rtl/ipp_step.sv
rtl/ipp_out_reg.sv
rtl/ipv4_port_text_parser_top.sv
dv/ipp_result_checker.sv
dv/tb_top.sv
